// ===== rtl/core/snfcs_pkg.sv =====
// Shared types, codes and helpers for the serial NOR flash command sequencer.
package snfcs_pkg;

    localparam int PageSizeDefault    = 256;
    localparam int AddressBitsDefault = 24;

    localparam logic [3:0] KIND_READ   = 4'd0;
    localparam logic [3:0] KIND_WRITE  = 4'd1;
    localparam logic [3:0] KIND_SERASE = 4'd2;
    localparam logic [3:0] KIND_CERASE = 4'd3;
    localparam logic [3:0] KIND_JEDEC  = 4'd4;
    localparam logic [3:0] KIND_DEVID  = 4'd5;
    localparam logic [3:0] KIND_SLEEP  = 4'd6;
    localparam logic [3:0] KIND_WAKE   = 4'd7;
    localparam logic [3:0] KIND_WBYTE  = 4'd8;
    localparam logic [3:0] KIND_RXBYTE = 4'd9;

    localparam logic [2:0] ACT_SEL  = 3'd0;
    localparam logic [2:0] ACT_XCH  = 3'd1;
    localparam logic [2:0] ACT_REL  = 3'd2;
    localparam logic [2:0] ACT_RD   = 3'd3;
    localparam logic [2:0] ACT_ID   = 3'd4;
    localparam logic [2:0] ACT_DONE = 3'd5;

    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_PP     = 8'h02;
    localparam logic [7:0] OP_RDSR   = 8'h05;
    localparam logic [7:0] OP_SE     = 8'h20;
    localparam logic [7:0] OP_CE     = 8'hC7;
    localparam logic [7:0] OP_JEDEC  = 8'h9F;
    localparam logic [7:0] OP_DEVID  = 8'hAB;
    localparam logic [7:0] OP_SLEEP  = 8'hB9;

    localparam logic [0:0] CFG_DUMMY_FILL = 1'b0;
    localparam logic [0:0] CFG_BUSY_MASK  = 1'b1;

    // Request as it crosses from the front to the back.
    typedef struct packed {
        logic [3:0]  kind;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  write_byte;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx_byte;
        logic [7:0]  read_byte;
        logic [23:0] id_value;
        logic        last;
    } result_t;

    function automatic logic [7:0] first_opcode(input logic [2:0] k);
        logic [7:0] op;
        unique case (k)
            3'd0:    op = OP_READ;
            3'd4:    op = OP_JEDEC;
            3'd5:    op = OP_DEVID;
            3'd6:    op = OP_SLEEP;
            3'd7:    op = OP_DEVID;
            default: op = OP_WREN;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/core/snfcs_fifo.sv =====
// Short request queue between the front and the back of the sequencer.
module snfcs_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [Width-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [Width-1:0] pop_data,
    output logic             empty
);
    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    logic [Width-1:0] mem_reg [Depth];
    logic [Aw-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [Aw:0]      count_reg;

    assign full     = (count_reg == (Aw+1)'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Aw'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Aw'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
        end
    end
endmodule

// ===== rtl/core/snfcs_front.sv =====
// Front part: accepts items, drops those of unknown kind, queues the rest.
module snfcs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  snfcs_pkg::item_t      in_item,
    output logic                  q_pop_valid,
    output snfcs_pkg::item_t      q_item,
    input  logic                  q_pop
);
    logic keep;
    logic full, empty;

    // Kinds above received byte never produce anything, so they are not queued.
    assign keep     = (in_item.kind <= snfcs_pkg::KIND_RXBYTE);
    assign in_stall = full;

    snfcs_fifo #(
        .Width($bits(snfcs_pkg::item_t)),
        .Depth(2)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid && keep),
        .push_data(in_item),
        .full     (full),
        .pop      (q_pop),
        .pop_data (q_item),
        .empty    (empty)
    );

    assign q_pop_valid = !empty;
endmodule

// ===== rtl/core/snfcs_back.sv =====
// Back part: the command state machine and its result sequencer.
module snfcs_back #(
    parameter int PageSize    = snfcs_pkg::PageSizeDefault,
    parameter int AddressBits = snfcs_pkg::AddressBitsDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  snfcs_pkg::item_t     q_item,
    output logic                 q_pop,
    input  logic [7:0]           dummy_fill,
    input  logic [7:0]           busy_mask,
    output logic                 out_valid,
    input  logic                 out_stall,
    output snfcs_pkg::result_t   out_res
);
    localparam int PageBits  = $clog2(PageSize);
    localparam int ChunkBits = PageBits + 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_OP, PH_ADDR, PH_RDATA, PH_ID, PH_WREN, PH_PRE_OP,
        PH_PRE_STAT, PH_STAT_OP, PH_STAT, PH_NEED, PH_WDATA
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             rkind_reg, rkind_next;
    logic [AddressBits-1:0] addr_reg, addr_next;
    logic [15:0]            left_reg, left_next;
    logic [ChunkBits-1:0]   chunk_reg, chunk_next;
    logic [2:0]             pos_reg, pos_next;
    logic [23:0]            idacc_reg, idacc_next;

    // Up to three results of one item are buffered and drained one a cycle while out_stall is low.
    snfcs_pkg::result_t     buf_reg [4];
    snfcs_pkg::result_t     buf_next [4];
    logic [2:0]             cnt_reg, cnt_next;
    logic [1:0]             rd_reg;
    logic [2:0]             n;
    logic                   take;

    logic [23:0]            addr24;
    logic [ChunkBits-1:0]   room;
    logic [AddressBits-1:0] plan_addr;
    logic [15:0]            plan_left;
    logic [ChunkBits-1:0]   plan_chunk;

    assign addr24    = 24'(addr_reg);
    assign out_valid = (cnt_reg != '0);
    assign out_res   = buf_reg[rd_reg];
    // A new item is taken once the previous results are all gone or the last leaves now.
    assign take      = q_valid && (cnt_reg == '0 ||
                       (cnt_reg == 3'd1 && !out_stall));
    assign q_pop     = take;

    always_comb
    begin
        room = ChunkBits'(PageSize) - {1'b0, plan_addr[PageBits-1:0]};
        if ({{(32-16){1'b0}}, plan_left} < 32'(room))
        begin
            plan_chunk = ChunkBits'(plan_left);
        end
        else
        begin
            plan_chunk = room;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        rkind_next = rkind_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        chunk_next = chunk_reg;
        pos_next   = pos_reg;
        idacc_next = idacc_reg;
        plan_addr  = addr_reg;
        plan_left  = left_reg;
        n          = '0;
        for (int i = 0; i < 4; i++)
        begin
            buf_next[i] = '0;
        end

        if (take)
        begin
            if (q_item.kind <= snfcs_pkg::KIND_WAKE)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    rkind_next = q_item.kind[2:0];
                    pos_next   = '0;
                    idacc_next = '0;
                    if (q_item.kind[2:0] <= 3'd2)
                    begin
                        addr_next = q_item.address[AddressBits-1:0];
                        left_next = q_item.length;
                    end
                    plan_addr = q_item.address[AddressBits-1:0];
                    plan_left = q_item.length;
                    if (q_item.kind == snfcs_pkg::KIND_WRITE && q_item.length == '0)
                    begin
                        buf_next[0].action = snfcs_pkg::ACT_DONE;
                        n = 3'd1;
                    end
                    else
                    begin
                        if (q_item.kind == snfcs_pkg::KIND_WRITE)
                        begin
                            chunk_next = plan_chunk;
                        end
                        buf_next[0].action  = snfcs_pkg::ACT_SEL;
                        buf_next[1].action  = snfcs_pkg::ACT_XCH;
                        buf_next[1].tx_byte = snfcs_pkg::first_opcode(q_item.kind[2:0]);
                        n = 3'd2;
                        phase_next = (q_item.kind[2:0] >= 3'd1 && q_item.kind[2:0] <= 3'd3)
                                     ? PH_WREN : PH_OP;
                    end
                end
            end
            else if (q_item.kind == snfcs_pkg::KIND_WBYTE)
            begin
                if (phase_reg == PH_NEED)
                begin
                    buf_next[0].action  = snfcs_pkg::ACT_XCH;
                    buf_next[0].tx_byte = q_item.write_byte;
                    n = 3'd1;
                    phase_next = PH_WDATA;
                end
            end
            else if (phase_reg != PH_IDLE && phase_reg != PH_NEED)
            begin
                unique case (phase_reg)
                    PH_WREN:
                    begin
                        buf_next[0].action = snfcs_pkg::ACT_REL;
                        buf_next[1].action = snfcs_pkg::ACT_SEL;
                        buf_next[2].action = snfcs_pkg::ACT_XCH;
                        n = 3'd3;
                        if (rkind_reg == 3'd1)
                        begin
                            buf_next[2].tx_byte = snfcs_pkg::OP_PP;
                            phase_next = PH_OP;
                        end
                        else if (rkind_reg == 3'd2)
                        begin
                            buf_next[2].tx_byte = snfcs_pkg::OP_RDSR;
                            phase_next = PH_PRE_OP;
                        end
                        else
                        begin
                            buf_next[2].tx_byte = snfcs_pkg::OP_CE;
                            phase_next = PH_OP;
                        end
                    end
                    PH_PRE_OP:
                    begin
                        buf_next[0].action  = snfcs_pkg::ACT_XCH;
                        buf_next[0].tx_byte = dummy_fill;
                        n = 3'd1;
                        phase_next = PH_PRE_STAT;
                    end
                    PH_PRE_STAT:
                    begin
                        if ((q_item.rx_byte & busy_mask) != '0)
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_XCH;
                            buf_next[0].tx_byte = dummy_fill;
                            n = 3'd1;
                        end
                        else
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_REL;
                            buf_next[1].action  = snfcs_pkg::ACT_SEL;
                            buf_next[2].action  = snfcs_pkg::ACT_XCH;
                            buf_next[2].tx_byte = snfcs_pkg::OP_SE;
                            n = 3'd3;
                            phase_next = PH_OP;
                        end
                    end
                    PH_OP:
                    begin
                        if (rkind_reg <= 3'd2)
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_XCH;
                            buf_next[0].tx_byte = addr24[23:16];
                            n = 3'd1;
                            pos_next = 3'd1;
                            phase_next = PH_ADDR;
                        end
                        else if (rkind_reg == 3'd3)
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_REL;
                            buf_next[1].action  = snfcs_pkg::ACT_SEL;
                            buf_next[2].action  = snfcs_pkg::ACT_XCH;
                            buf_next[2].tx_byte = snfcs_pkg::OP_RDSR;
                            n = 3'd3;
                            phase_next = PH_STAT_OP;
                        end
                        else if (rkind_reg == 3'd4 || rkind_reg == 3'd5)
                        begin
                            pos_next   = '0;
                            idacc_next = '0;
                            buf_next[0].action  = snfcs_pkg::ACT_XCH;
                            buf_next[0].tx_byte = dummy_fill;
                            n = 3'd1;
                            phase_next = PH_ID;
                        end
                        else
                        begin
                            buf_next[0].action = snfcs_pkg::ACT_REL;
                            buf_next[1].action = snfcs_pkg::ACT_DONE;
                            n = 3'd2;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (pos_reg < 3'd3)
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_XCH;
                            buf_next[0].tx_byte = (pos_reg == 3'd1) ? addr24[15:8]
                                                                    : addr24[7:0];
                            n = 3'd1;
                            pos_next = pos_reg + 3'd1;
                        end
                        else if (rkind_reg == 3'd0)
                        begin
                            if (left_reg != '0)
                            begin
                                buf_next[0].action  = snfcs_pkg::ACT_XCH;
                                buf_next[0].tx_byte = dummy_fill;
                                n = 3'd1;
                                phase_next = PH_RDATA;
                            end
                            else
                            begin
                                buf_next[0].action = snfcs_pkg::ACT_REL;
                                buf_next[1].action = snfcs_pkg::ACT_DONE;
                                n = 3'd2;
                                phase_next = PH_IDLE;
                            end
                        end
                        else if (rkind_reg == 3'd1)
                        begin
                            phase_next = PH_NEED;
                        end
                        else
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_REL;
                            buf_next[1].action  = snfcs_pkg::ACT_SEL;
                            buf_next[2].action  = snfcs_pkg::ACT_XCH;
                            buf_next[2].tx_byte = snfcs_pkg::OP_RDSR;
                            n = 3'd3;
                            phase_next = PH_STAT_OP;
                        end
                    end
                    PH_RDATA:
                    begin
                        buf_next[0].action    = snfcs_pkg::ACT_RD;
                        buf_next[0].read_byte = q_item.rx_byte;
                        left_next = left_reg - 16'd1;
                        addr_next = addr_reg + 1'b1;
                        if (left_reg != 16'd1)
                        begin
                            buf_next[1].action  = snfcs_pkg::ACT_XCH;
                            buf_next[1].tx_byte = dummy_fill;
                            n = 3'd2;
                        end
                        else
                        begin
                            buf_next[1].action = snfcs_pkg::ACT_REL;
                            buf_next[2].action = snfcs_pkg::ACT_DONE;
                            n = 3'd3;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ID:
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (rkind_reg == 3'd4)
                        begin
                            idacc_next = {idacc_reg[15:0], q_item.rx_byte};
                        end
                        else
                        begin
                            idacc_next = {16'd0, q_item.rx_byte};
                        end
                        if ((rkind_reg == 3'd4 && pos_next < 3'd3) ||
                            (rkind_reg != 3'd4 && pos_next < 3'd4))
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_XCH;
                            buf_next[0].tx_byte = dummy_fill;
                            n = 3'd1;
                        end
                        else
                        begin
                            buf_next[0].action   = snfcs_pkg::ACT_ID;
                            buf_next[0].id_value = idacc_next;
                            buf_next[1].action   = snfcs_pkg::ACT_REL;
                            buf_next[2].action   = snfcs_pkg::ACT_DONE;
                            n = 3'd3;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WDATA:
                    begin
                        chunk_next = chunk_reg - 1'b1;
                        left_next  = left_reg - 16'd1;
                        addr_next  = addr_reg + 1'b1;
                        if (chunk_next != '0)
                        begin
                            phase_next = PH_NEED;
                        end
                        else
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_REL;
                            buf_next[1].action  = snfcs_pkg::ACT_SEL;
                            buf_next[2].action  = snfcs_pkg::ACT_XCH;
                            buf_next[2].tx_byte = snfcs_pkg::OP_RDSR;
                            n = 3'd3;
                            phase_next = PH_STAT_OP;
                        end
                    end
                    PH_STAT_OP:
                    begin
                        buf_next[0].action  = snfcs_pkg::ACT_XCH;
                        buf_next[0].tx_byte = dummy_fill;
                        n = 3'd1;
                        phase_next = PH_STAT;
                    end
                    PH_STAT:
                    begin
                        if ((q_item.rx_byte & busy_mask) != '0)
                        begin
                            buf_next[0].action  = snfcs_pkg::ACT_XCH;
                            buf_next[0].tx_byte = dummy_fill;
                            n = 3'd1;
                        end
                        else if (rkind_reg == 3'd1 && left_reg != '0)
                        begin
                            chunk_next = plan_chunk;
                            buf_next[0].action  = snfcs_pkg::ACT_REL;
                            buf_next[1].action  = snfcs_pkg::ACT_SEL;
                            buf_next[2].action  = snfcs_pkg::ACT_XCH;
                            buf_next[2].tx_byte = snfcs_pkg::OP_WREN;
                            n = 3'd3;
                            phase_next = PH_WREN;
                        end
                        else
                        begin
                            buf_next[0].action = snfcs_pkg::ACT_REL;
                            buf_next[1].action = snfcs_pkg::ACT_DONE;
                            n = 3'd2;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            if (n != '0)
            begin
                buf_next[n[1:0] - 2'd1].last = 1'b1;
            end
        end
        cnt_next = cnt_reg;
        if (out_valid && !out_stall)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
        if (take)
        begin
            cnt_next = n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 4; i++)
            begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rkind_reg <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
            chunk_reg <= '0;
            pos_reg   <= '0;
            idacc_reg <= '0;
            cnt_reg   <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rkind_reg <= rkind_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            chunk_reg <= chunk_next;
            pos_reg   <= pos_next;
            idacc_reg <= idacc_next;
            cnt_reg   <= cnt_next;
            if (take)
            begin
                rd_reg <= '0;
            end
            else if (out_valid && !out_stall)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
        end
    end
endmodule

// ===== rtl/core/spi_nor_flash_command_sequencer.sv =====
// Top level of the serial NOR flash command sequencer.
//
//  channel   direction  handshake            payload
//  in        request    in_valid/in_stall    kind address length write_byte rx_byte
//  out       result     out_valid/out_stall  action tx_byte read_byte id_value last
//  cfg       write      cfg_we               cfg_index cfg_data
//
// One item enters per cycle while the back is free. An item's results, at most three,
// leave through the single result port that drains the result buffer, and the back takes
// no new item until its last result leaves. A two-entry queue separates front and back.
// Reset is asynchronous and active low and leaves the sequencer idle.
// out_stall only holds the result buffer; the queue keeps taking requests until full.
module spi_nor_flash_command_sequencer #(
    parameter int PageSize    = snfcs_pkg::PageSizeDefault,
    parameter int AddressBits = snfcs_pkg::AddressBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  kind,
    input  logic [23:0] address,
    input  logic [15:0] length,
    input  logic [7:0]  write_byte,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [7:0]  tx_byte,
    output logic [7:0]  read_byte,
    output logic [23:0] id_value,
    output logic        last,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    snfcs_pkg::item_t   in_item, q_item;
    snfcs_pkg::result_t res;
    logic               q_valid, q_pop;
    logic [7:0]         dummy_fill_reg, busy_mask_reg;

    assign in_item = '{kind: kind, address: address, length: length,
                       write_byte: write_byte, rx_byte: rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dummy_fill_reg <= 8'hFF;
            busy_mask_reg  <= 8'h01;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                snfcs_pkg::CFG_DUMMY_FILL: dummy_fill_reg <= cfg_data;
                snfcs_pkg::CFG_BUSY_MASK:  busy_mask_reg  <= cfg_data;
                default:                   dummy_fill_reg <= dummy_fill_reg;
            endcase
        end
    end

    snfcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .q_pop_valid(q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    snfcs_back #(
        .PageSize   (PageSize),
        .AddressBits(AddressBits)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .dummy_fill(dummy_fill_reg),
        .busy_mask (busy_mask_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    assign action    = res.action;
    assign tx_byte   = res.tx_byte;
    assign read_byte = res.read_byte;
    assign id_value  = res.id_value;
    assign last      = res.last;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) && $stable(last))
        else $error("result changed while stalled");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> action <= snfcs_pkg::ACT_DONE)
        else $error("undefined action code");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == snfcs_pkg::ACT_DONE |-> last)
        else $error("request complete not marked last");
endmodule
